@@ sv/ptbl_pkg.sv @@
// ---------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants for the per-client token bucket limiter.
// ---------------------------------------------------------------------------
package ptbl_pkg;

   // Field widths.
   localparam int unsigned CLIENT_W    = 4;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned TOKEN_W     = 16;
   localparam int unsigned RATE_W      = 16;
   localparam int unsigned PRODUCT_W   = TIME_W + RATE_W;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   // Defaults.
   localparam int unsigned NUM_CLIENTS_DEFAULT = 16;
   localparam logic [TOKEN_W-1:0] MAX_TOKENS_RESET  = 16'd5;
   localparam logic [RATE_W-1:0]  REFILL_RATE_RESET = 16'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_TOKENS  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REFILL_RATE = 4'd1;

   // One bucket entry as held in the state memory.
   typedef struct packed {
      logic               seen;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  last_time;
   } bucket_entry_type;

   // Outcome of one refill and take step.
   typedef struct packed {
      logic               allowed;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  last_time;
   } update_result_type;

endpackage

@@ sv/ptbl_refill.sv @@
// ---------------------------------------------------------------------------
// ptbl_refill
// Refills a bucket by a precomputed token product, clipping a refill at capacity,
// and takes one token if any is present.
// ---------------------------------------------------------------------------
module ptbl_refill (
   input  logic [ptbl_pkg::TOKEN_W-1:0]   tokens,
   input  logic [ptbl_pkg::TIME_W-1:0]    last_time,
   input  logic [ptbl_pkg::TIME_W-1:0]    now_seconds,
   input  logic [ptbl_pkg::PRODUCT_W-1:0] product,
   input  logic [ptbl_pkg::TOKEN_W-1:0]   max_tokens,
   output ptbl_pkg::update_result_type    result
);

   logic [ptbl_pkg::PRODUCT_W:0]   sum;
   logic [ptbl_pkg::TOKEN_W-1:0]   level;
   logic [ptbl_pkg::TIME_W-1:0]    new_time;

   // Refill only when tokens are actually added; a refill clips to capacity.
   always_comb begin
      sum = (ptbl_pkg::PRODUCT_W+1)'(tokens) + (ptbl_pkg::PRODUCT_W+1)'(product);
      if (product != '0) begin
         if (sum > (ptbl_pkg::PRODUCT_W+1)'(max_tokens)) begin
            level = max_tokens;
         end else begin
            level = sum[ptbl_pkg::TOKEN_W-1:0];
         end
         new_time = now_seconds;
      end else begin
         level    = tokens;
         new_time = last_time;
      end
   end

   // Take one token when the bucket is not empty.
   always_comb begin
      result.last_time = new_time;
      if (level != '0) begin
         result.allowed = 1'b1;
         result.tokens  = level - ptbl_pkg::TOKEN_W'(1);
      end else begin
         result.allowed = 1'b0;
         result.tokens  = level;
      end
   end

endmodule

@@ sv/per_client_token_bucket_limiter.sv @@
// A result is registered after the memory read, the multiply and the write-back
// steps after acceptance, and is shown for one cycle. No new item is taken
// until the last one is through these steps; busy stays high meanwhile.
// Reset: synchronous; afterwards a clearing pass over all NUM_CLIENTS entries
// marks every bucket unseen, with busy high. Configuration writes are taken at
// any time. The receiver cannot stall results.
// ---------------------------------------------------------------------------
// per_client_token_bucket_limiter
// Keeps one token bucket per client in a synchronous memory and answers each
// request with an admit verdict and the tokens left.
// ---------------------------------------------------------------------------
module per_client_token_bucket_limiter #(
   parameter int unsigned NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ptbl_pkg::CLIENT_W-1:0]       req_client_id,
   input  logic [ptbl_pkg::TIME_W-1:0]         req_now_seconds,
   output logic                                rsp_valid,
   output logic                                rsp_allowed,
   output logic [ptbl_pkg::TOKEN_W-1:0]        rsp_tokens_left,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ptbl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptbl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_CALC  = 4'b0100,
      S_UPD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ptbl_pkg::TOKEN_W-1:0] max_tokens_ff;
   logic [ptbl_pkg::RATE_W-1:0]  refill_rate_ff;

   // Bucket memory and its registered read port.
   ptbl_pkg::bucket_entry_type mem [NUM_CLIENTS];
   ptbl_pkg::bucket_entry_type rd_ff;

   // Item context.
   logic [IDX_W-1:0]               addr_ff;
   logic                           in_range_ff;
   logic [ptbl_pkg::TIME_W-1:0]    now_ff;
   logic [ptbl_pkg::TOKEN_W-1:0]   tok0_ff;
   logic [ptbl_pkg::TIME_W-1:0]    time0_ff;
   logic [ptbl_pkg::PRODUCT_W-1:0] product_ff;
   logic [IDX_W-1:0]               clr_ff;

   // Response registers.
   logic                         rsp_valid_ff;
   logic                         rsp_allowed_ff;
   logic [ptbl_pkg::TOKEN_W-1:0] rsp_tokens_ff;

   logic                                  accept;
   logic [ptbl_pkg::CLIENT_W+IDX_W-1:0]   id_wide;
   logic [IDX_W-1:0]                      req_addr;
   logic                                  req_in_range;
   logic [ptbl_pkg::TOKEN_W-1:0]          tok0_in;
   logic [ptbl_pkg::TIME_W-1:0]           time0_in;
   logic [ptbl_pkg::TIME_W-1:0]           elapsed;
   ptbl_pkg::update_result_type           upd;
   logic                                  mem_we;
   logic [IDX_W-1:0]                      mem_waddr;
   ptbl_pkg::bucket_entry_type            mem_wdata;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Request address, sized to the memory depth.
   assign id_wide      = (ptbl_pkg::CLIENT_W+IDX_W)'(req_client_id);
   assign req_addr     = id_wide[IDX_W-1:0];
   assign req_in_range = (32'(req_client_id) < 32'(NUM_CLIENTS));

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == LAST_IDX) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_CALC;
         S_CALC:  state_in = S_UPD;
         S_UPD:   state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
      end
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff  <= ptbl_pkg::MAX_TOKENS_RESET;
         refill_rate_ff <= ptbl_pkg::REFILL_RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ptbl_pkg::REG_MAX_TOKENS:  max_tokens_ff  <= csr_wdata;
            ptbl_pkg::REG_REFILL_RATE: refill_rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A client seen for the first time starts full with its time set to now.
   always_comb begin
      if (rd_ff.seen) begin
         tok0_in  = rd_ff.tokens;
         time0_in = rd_ff.last_time;
      end else begin
         tok0_in  = max_tokens_ff;
         time0_in = now_ff;
      end
      elapsed = now_ff - time0_in;
   end

   // Item context capture and the elapsed-time product.
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff     <= req_addr;
         in_range_ff <= req_in_range;
         now_ff      <= req_now_seconds;
      end
      if (state_ff == S_CALC) begin
         tok0_ff    <= tok0_in;
         time0_ff   <= time0_in;
         product_ff <= ptbl_pkg::PRODUCT_W'(elapsed)
                       * ptbl_pkg::PRODUCT_W'(refill_rate_ff);
      end
   end

   ptbl_refill u_refill (
      .tokens      (tok0_ff),
      .last_time   (time0_ff),
      .now_seconds (now_ff),
      .product     (product_ff),
      .max_tokens  (max_tokens_ff),
      .result      (upd)
   );

   // Memory write port: the clearing pass or the bucket write-back.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we              = (state_ff == S_UPD) && in_range_ff;
         mem_waddr           = addr_ff;
         mem_wdata.seen      = 1'b1;
         mem_wdata.tokens    = upd.tokens;
         mem_wdata.last_time = upd.last_time;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_ff <= mem[req_addr];
      end
   end

   // Result registers; an out-of-range client is refused with zero tokens.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_UPD);
      end
      if (state_ff == S_UPD) begin
         rsp_allowed_ff <= in_range_ff && upd.allowed;
         rsp_tokens_ff  <= in_range_ff ? upd.tokens : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_allowed     = rsp_allowed_ff;
   assign rsp_tokens_left = rsp_tokens_ff;

endmodule

@@ sv/ptbl_checker.sv @@
// ---------------------------------------------------------------------------
// ptbl_checker
// Port-level timing checks for the token bucket limiter, bound to the top.
// ---------------------------------------------------------------------------
module ptbl_checker #(
   parameter int unsigned NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [ptbl_pkg::CLIENT_W-1:0] req_client_id,
   input logic                          rsp_valid,
   input logic                          rsp_allowed,
   input logic [ptbl_pkg::TOKEN_W-1:0]  rsp_tokens_left
);

   // Every accepted item yields a result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("result missing three cycles after an accepted item");

   // The block stays busy while an item is at work.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy)
      else $error("block not busy while an item is at work");

   // A result strobe lasts a single cycle and coincides with readiness.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && !$past(rsp_valid)))
      else $error("result strobe longer than one cycle or while busy");

   // An unknown client is refused with an empty bucket.
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (32'(req_client_id) >= 32'(NUM_CLIENTS)))
      |-> ##3 (!rsp_allowed && (rsp_tokens_left == '0)))
      else $error("out-of-range client was not refused");

endmodule

bind per_client_token_bucket_limiter ptbl_checker #(
   .NUM_CLIENTS (NUM_CLIENTS)
) u_ptbl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_client_id   (req_client_id),
   .rsp_valid       (rsp_valid),
   .rsp_allowed     (rsp_allowed),
   .rsp_tokens_left (rsp_tokens_left)
);

@@ tb/per_client_token_bucket_limiter_tb.sv @@
// ---------------------------------------------------------------------------
// per_client_token_bucket_limiter_tb
// Self-checking bench for the per-client token bucket limiter. A short
// directed list covers new clients, empty buckets, wrapped and backward time,
// saturating refills, lowered capacity, zero capacity and ignored register
// indexes. Random phases follow under several register settings and idle
// rates. Every result is compared with the row's typed value or a bucket model.
// ---------------------------------------------------------------------------
module per_client_token_bucket_limiter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_CLIENTS = ptbl_pkg::NUM_CLIENTS_DEFAULT;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned RANDOM_PHASES = 14;
   localparam int unsigned ITEMS_PER_PHASE = 95;

   // Register indexes that the block must ignore.
   localparam logic [ptbl_pkg::CSR_INDEX_W-1:0] REG_UNUSED_LO = 4'd2;
   localparam logic [ptbl_pkg::CSR_INDEX_W-1:0] REG_UNUSED_HI = 4'd15;

   typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                     kind;
      logic [ptbl_pkg::CLIENT_W-1:0]    client;
      logic [ptbl_pkg::TIME_W-1:0]      now_s;
      logic [ptbl_pkg::CSR_INDEX_W-1:0] index;
      logic [ptbl_pkg::CSR_DATA_W-1:0]  wdata;
      bit                               typed;
      logic                             allowed;
      logic [ptbl_pkg::TOKEN_W-1:0]     tokens_left;
   } stim_row_type;

   typedef struct packed {
      logic [ptbl_pkg::CLIENT_W-1:0] client;
      logic                          allowed;
      logic [ptbl_pkg::TOKEN_W-1:0]  tokens_left;
   } verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [ptbl_pkg::CLIENT_W-1:0]    req_client_id = '0;
   logic [ptbl_pkg::TIME_W-1:0]      req_now_seconds = '0;
   logic                             rsp_valid;
   logic                             rsp_allowed;
   logic [ptbl_pkg::TOKEN_W-1:0]     rsp_tokens_left;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ptbl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ptbl_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Bucket model state and its copy of the registers.
   logic [ptbl_pkg::TOKEN_W-1:0] bucket_capacity = ptbl_pkg::MAX_TOKENS_RESET;
   logic [ptbl_pkg::RATE_W-1:0]  fill_rate = ptbl_pkg::REFILL_RATE_RESET;
   logic [ptbl_pkg::TOKEN_W-1:0] model_tokens[NUM_CLIENTS];
   logic [ptbl_pkg::TIME_W-1:0]  model_stamp[NUM_CLIENTS];
   bit                           model_seen[NUM_CLIENTS];

   verdict_type                 pending_verdicts[$];
   stim_row_type                directed_rows[$];
   logic [ptbl_pkg::TIME_W-1:0] client_clock[NUM_CLIENTS];
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;

   per_client_token_bucket_limiter #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_client_id   (req_client_id),
      .req_now_seconds (req_now_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_allowed     (rsp_allowed),
      .rsp_tokens_left (rsp_tokens_left),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Refill the client's bucket, take a token if one is there, and report.
   function automatic verdict_type predict_admission(
      input logic [ptbl_pkg::CLIENT_W-1:0] client,
      input logic [ptbl_pkg::TIME_W-1:0]   now_s);
      verdict_type                    verdict;
      logic [ptbl_pkg::TIME_W-1:0]    elapsed;
      logic [ptbl_pkg::PRODUCT_W-1:0] gain;
      logic [ptbl_pkg::PRODUCT_W:0]   level;
      verdict.client = client;
      verdict.allowed = 1'b0;
      verdict.tokens_left = '0;
      if (int'(client) >= NUM_CLIENTS) begin
         return verdict;
      end
      if (!model_seen[client]) begin
         model_seen[client] = 1'b1;
         model_tokens[client] = bucket_capacity;
         model_stamp[client] = now_s;
      end
      elapsed = now_s - model_stamp[client];
      gain = ptbl_pkg::PRODUCT_W'(elapsed) * ptbl_pkg::PRODUCT_W'(fill_rate);
      // The stamp moves and the level is capped only when tokens were added.
      if (gain != '0) begin
         level = (ptbl_pkg::PRODUCT_W+1)'(model_tokens[client])
                 + (ptbl_pkg::PRODUCT_W+1)'(gain);
         if (level > (ptbl_pkg::PRODUCT_W+1)'(bucket_capacity)) begin
            level = (ptbl_pkg::PRODUCT_W+1)'(bucket_capacity);
         end
         model_tokens[client] = level[ptbl_pkg::TOKEN_W-1:0];
         model_stamp[client] = now_s;
      end
      if (model_tokens[client] != '0) begin
         model_tokens[client] = model_tokens[client] - 1'b1;
         verdict.allowed = 1'b1;
      end
      verdict.tokens_left = model_tokens[client];
      return verdict;
   endfunction

   function automatic stim_row_type request_row(
      input logic [ptbl_pkg::CLIENT_W-1:0] client,
      input logic [ptbl_pkg::TIME_W-1:0]   now_s);
      stim_row_type row;
      row.kind = ROW_REQUEST;
      row.client = client;
      row.now_s = now_s;
      row.index = '0;
      row.wdata = '0;
      row.typed = 1'b0;
      row.allowed = 1'b0;
      row.tokens_left = '0;
      return row;
   endfunction

   function automatic stim_row_type checked_row(
      input logic [ptbl_pkg::CLIENT_W-1:0] client,
      input logic [ptbl_pkg::TIME_W-1:0]   now_s,
      input logic                          allowed,
      input logic [ptbl_pkg::TOKEN_W-1:0]  tokens_left);
      stim_row_type row;
      row = request_row(client, now_s);
      row.typed = 1'b1;
      row.allowed = allowed;
      row.tokens_left = tokens_left;
      return row;
   endfunction

   function automatic stim_row_type register_row(
      input logic [ptbl_pkg::CSR_INDEX_W-1:0] index,
      input logic [ptbl_pkg::CSR_DATA_W-1:0]  wdata);
      stim_row_type row;
      row = request_row('0, '0);
      row.kind = ROW_REG_WRITE;
      row.index = index;
      row.wdata = wdata;
      return row;
   endfunction

   // Offer one item, after an optional idle gap, and record its expected verdict.
   task automatic issue_request(input logic [ptbl_pkg::CLIENT_W-1:0] client,
                                input logic [ptbl_pkg::TIME_W-1:0] now_s,
                                input int unsigned idle_pct,
                                input bit typed,
                                input logic allowed,
                                input logic [ptbl_pkg::TOKEN_W-1:0] tokens_left);
      verdict_type verdict;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_client_id <= client;
      req_now_seconds <= now_s;
      @(posedge clock);
      while (busy) @(posedge clock);
      verdict = predict_admission(client, now_s);
      if (typed) begin
         verdict.allowed = allowed;
         verdict.tokens_left = tokens_left;
      end
      pending_verdicts.push_back(verdict);
   endtask

   // Hold valid high until the write is taken, then mirror it in the model.
   task automatic write_reg(input logic [ptbl_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ptbl_pkg::CSR_DATA_W-1:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == ptbl_pkg::REG_MAX_TOKENS) begin
         bucket_capacity = wdata;
      end else if (index == ptbl_pkg::REG_REFILL_RATE) begin
         fill_rate = wdata;
      end
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic settle_block();
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Compare each result with the oldest pending verdict.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("Unexpected result: allowed=%0d tokens_left=%0d",
                        rsp_allowed, rsp_tokens_left);
            end
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_allowed !== want.allowed || rsp_tokens_left !== want.tokens_left) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Mismatch client %0d: expected allowed=%0d tokens_left=%0d, %s",
                           want.client, want.allowed, want.tokens_left,
                           $sformatf("got allowed=%0d tokens_left=%0d",
                                     rsp_allowed, rsp_tokens_left));
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      bit                            in_reg_writes;
      int unsigned                   idle_pct;
      logic [ptbl_pkg::TOKEN_W-1:0]  cap;
      logic [ptbl_pkg::RATE_W-1:0]   rate;
      logic [ptbl_pkg::CLIENT_W-1:0] client;
      logic [ptbl_pkg::TIME_W-1:0]   now_s;

      foreach (client_clock[i]) client_clock[i] = '0;

      // New client, draining an empty bucket, wrapped and backward time.
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b1, 16'd4));
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b1, 16'd3));
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b1, 16'd2));
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b1, 16'd1));
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b1, 16'd0));
      directed_rows.push_back(checked_row(4'd0, 32'd0, 1'b0, 16'd0));
      directed_rows.push_back(request_row(4'd0, 32'd1));
      directed_rows.push_back(checked_row(4'd15, 32'hFFFF_FFFF, 1'b1, 16'd4));
      directed_rows.push_back(request_row(4'd15, 32'd0));
      directed_rows.push_back(request_row(4'd15, 32'hFFFF_FFF0));
      // Largest capacity and rate: the refill product must not overflow.
      directed_rows.push_back(register_row(ptbl_pkg::REG_MAX_TOKENS, 16'hFFFF));
      directed_rows.push_back(register_row(ptbl_pkg::REG_REFILL_RATE, 16'hFFFF));
      directed_rows.push_back(checked_row(4'd1, 32'h1234_5678, 1'b1, 16'hFFFE));
      directed_rows.push_back(request_row(4'd1, 32'h1234_5679));
      directed_rows.push_back(request_row(4'd0, 32'hFFFF_FFFF));
      // Lowered capacity: a full bucket stays above it until a refill clips it.
      directed_rows.push_back(register_row(ptbl_pkg::REG_MAX_TOKENS, 16'd3));
      directed_rows.push_back(register_row(ptbl_pkg::REG_REFILL_RATE, 16'd0));
      directed_rows.push_back(checked_row(4'd1, 32'h1234_5679, 1'b1, 16'hFFFD));
      directed_rows.push_back(checked_row(4'd1, 32'h9999_9999, 1'b1, 16'hFFFC));
      directed_rows.push_back(register_row(ptbl_pkg::REG_REFILL_RATE, 16'd1));
      directed_rows.push_back(checked_row(4'd1, 32'h9999_999A, 1'b1, 16'd2));
      // Zero capacity refuses everything.
      directed_rows.push_back(register_row(ptbl_pkg::REG_MAX_TOKENS, 16'd0));
      directed_rows.push_back(checked_row(4'd2, 32'd5, 1'b0, 16'd0));
      directed_rows.push_back(checked_row(4'd2, 32'd6, 1'b0, 16'd0));
      // Writes to unused indexes change nothing.
      directed_rows.push_back(register_row(REG_UNUSED_HI, 16'hAAAA));
      directed_rows.push_back(register_row(REG_UNUSED_LO, 16'h5555));
      directed_rows.push_back(register_row(ptbl_pkg::REG_MAX_TOKENS, 16'd1));
      directed_rows.push_back(checked_row(4'd3, 32'd100, 1'b1, 16'd0));
      directed_rows.push_back(checked_row(4'd3, 32'd100, 1'b0, 16'd0));
      directed_rows.push_back(checked_row(4'd3, 32'd101, 1'b1, 16'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, back to back.
      in_reg_writes = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG_WRITE) begin
            if (!in_reg_writes) begin
               settle_block();
               in_reg_writes = 1'b1;
            end
            write_reg(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            if (in_reg_writes) begin
               csr_valid <= 1'b0;
               in_reg_writes = 1'b0;
            end
            issue_request(directed_rows[i].client, directed_rows[i].now_s, 0,
                          directed_rows[i].typed, directed_rows[i].allowed,
                          directed_rows[i].tokens_left);
         end
      end

      // Random phases, each under its own register setting and idle rate.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 67;
            default: idle_pct = 11;
         endcase
         case (phase % 7)
            0: begin
               cap = ptbl_pkg::MAX_TOKENS_RESET;
               rate = ptbl_pkg::REFILL_RATE_RESET;
            end
            1: begin cap = 16'd1; rate = 16'd0; end
            2: begin cap = 16'd3; rate = 16'd1; end
            3: begin cap = 16'hFFFF; rate = 16'hFFFF; end
            4: begin cap = 16'($urandom_range(1, 20)); rate = 16'($urandom_range(0, 4)); end
            5: begin cap = 16'd2; rate = 16'hFFFF; end
            default: begin cap = 16'($urandom_range(1, 65535)); rate = 16'($urandom); end
         endcase
         settle_block();
         if ($urandom_range(1)) begin
            write_reg(ptbl_pkg::REG_MAX_TOKENS, cap);
            write_reg(ptbl_pkg::REG_REFILL_RATE, rate);
         end else begin
            write_reg(ptbl_pkg::REG_REFILL_RATE, rate);
            write_reg(ptbl_pkg::REG_MAX_TOKENS, cap);
         end
         if ($urandom_range(3) == 0) begin
            write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
         end
         csr_valid <= 1'b0;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Mostly a few busy clients whose time creeps forward.
            if ($urandom_range(3) != 0) begin
               client = 4'($urandom_range(0, 3));
            end else begin
               client = 4'($urandom_range(0, NUM_CLIENTS - 1));
            end
            if ($urandom_range(99) < 85) begin
               if ($urandom_range(9) >= 6) begin
                  client_clock[client] = client_clock[client] + $urandom_range(1, 3);
               end
               now_s = client_clock[client];
            end else begin
               // Arbitrary time, which may jump far ahead or go backwards.
               now_s = $urandom;
               if ($urandom_range(1)) begin
                  client_clock[client] = now_s;
               end
            end
            issue_request(client, now_s, idle_pct, 1'b0, 1'b0, '0);
         end
      end

      settle_block();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
